### rtl/ccs_pkg.sv
// Package for the chunked CRC-16 sum unit: beat types, constants, CRC byte step.
`default_nettype none
package ccs_pkg;

    localparam int unsigned LenWidth   = 13;
    localparam int unsigned CountWidth = 12;
    localparam int unsigned CrcWidth   = 16;
    localparam int unsigned SumWidth   = 32;

    localparam logic [LenWidth-1:0] ChunkLenReset = 13'd16;
    localparam logic [LenWidth-1:0] ChunkLenMax   = 13'd4096;
    localparam logic [LenWidth-1:0] ChunkLenMin   = 13'd1;
    localparam logic [CrcWidth-1:0] CrcInit       = 16'hFFFF;
    localparam logic [CrcWidth-1:0] CrcPolyRefl   = 16'hA001;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [SumWidth-1:0] checksum_sum;
        logic                partial_tail;
    } t_out_beat;

    // One byte through the reflected CRC-16/MODBUS.
    function automatic logic [CrcWidth-1:0] crc_byte(
        input logic [CrcWidth-1:0] crc_in,
        input logic [7:0]          data
    );
        logic [CrcWidth-1:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CrcPolyRefl;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

### rtl/ccs_core.sv
// Chunk state of the CRC sum unit: running CRC, chunk byte count, wrapping sum.
`default_nettype none
module ccs_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire ccs_pkg::t_in_beat            i_item,
    input  wire logic [ccs_pkg::LenWidth-1:0] i_chunk_length,
    output ccs_pkg::t_out_beat                o_result
);

    logic [ccs_pkg::CrcWidth-1:0]   r_crc, n_crc;
    logic [ccs_pkg::CountWidth-1:0] r_count, n_count;
    logic [ccs_pkg::SumWidth-1:0]   r_sum, n_sum;

    logic [ccs_pkg::CrcWidth-1:0]   crc_next;
    logic [ccs_pkg::LenWidth-1:0]   eff_len;
    logic [ccs_pkg::LenWidth-1:0]   taken;
    logic                           chunk_done;
    logic [ccs_pkg::SumWidth-1:0]   sum_next;
    logic [ccs_pkg::CountWidth-1:0] count_next;

    always_comb begin
        if (i_chunk_length == '0) begin
            eff_len = ccs_pkg::ChunkLenMin;
        end else if (i_chunk_length > ccs_pkg::ChunkLenMax) begin
            eff_len = ccs_pkg::ChunkLenMax;
        end else begin
            eff_len = i_chunk_length;
        end
    end

    assign crc_next   = ccs_pkg::crc_byte(r_crc, i_item.data_byte);
    assign taken      = {1'b0, r_count} + ccs_pkg::LenWidth'(1);
    assign chunk_done = (taken >= eff_len);
    assign sum_next   = chunk_done
                      ? r_sum + {16'h0000, crc_next[7:0], crc_next[15:8]}
                      : r_sum;
    assign count_next = chunk_done ? '0 : taken[ccs_pkg::CountWidth-1:0];

    assign o_result.checksum_sum = sum_next;
    assign o_result.partial_tail = (count_next != '0);

    always_comb begin
        n_crc   = r_crc;
        n_count = r_count;
        n_sum   = r_sum;
        if (i_step) begin
            if (i_item.last_byte) begin
                n_crc   = ccs_pkg::CrcInit;
                n_count = '0;
                n_sum   = '0;
            end else begin
                n_crc   = chunk_done ? ccs_pkg::CrcInit : crc_next;
                n_count = count_next;
                n_sum   = sum_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= ccs_pkg::CrcInit;
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_crc   <= n_crc;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

endmodule
`default_nettype wire

### rtl/chunked_crc16_sum_unit.sv
// Top level of the chunked CRC-16/MODBUS sum unit.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one byte per beat,
// with a last_byte flag marking the end of a region. Bytes are cut into
// chunks of chunk_length bytes (0 acts as 1, above 4096 acts as 4096); each
// chunk's CRC-16/MODBUS, byte-swapped, is added into a wrapping 32-bit sum.
// Output channel (o_out_valid / i_out_ready / o_out_data): one beat per
// region, on its last byte: the sum and a flag for a dropped partial tail.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): chunk length,
// always ready; write it only while the unit is idle.
// A byte waits in the input register and is folded into the chunk state when
// it steps; the result register loads as a last byte steps. Throughput: one
// byte per cycle unless a last byte is held back, set by the single byte-wide
// CRC step and 32-bit add between input and result registers.
// Reset clears the chunk state and sets the chunk length to 16. While the
// receiver stalls a pending result, non-last bytes keep flowing; a last
// byte waits in the input register until the result register frees up.
`default_nettype none
module chunked_crc16_sum_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output      logic                         o_in_ready,
    input  wire ccs_pkg::t_in_beat            i_in_data,
    output      logic                         o_out_valid,
    input  wire logic                         i_out_ready,
    output      ccs_pkg::t_out_beat           o_out_data,
    input  wire logic                         i_cfg_valid,
    output      logic                         o_cfg_ready,
    input  wire logic [ccs_pkg::LenWidth-1:0] i_cfg_data
);

    logic [ccs_pkg::LenWidth-1:0] r_chunk_len;
    logic                         r_in_valid;
    ccs_pkg::t_in_beat            r_in;
    logic                         r_out_valid;
    ccs_pkg::t_out_beat           r_out;

    ccs_pkg::t_out_beat core_result;
    logic               step_go;

    assign step_go     = r_in_valid && (!r_in.last_byte || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step_go;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    ccs_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step_go),
        .i_item         (r_in),
        .i_chunk_length (r_chunk_len),
        .o_result       (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_len <= ccs_pkg::ChunkLenReset;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_chunk_len <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step_go && r_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (step_go && r_in.last_byte) begin
            r_out <= core_result;
        end
    end

endmodule
`default_nettype wire
